>>> rtl/cgnr_pkg.sv
package cgnr_pkg;

  localparam int MaxRows     = 256;
  localparam int MaxCols     = 256;
  localparam int BisectLimit = 100;
  localparam int RowW        = $clog2(MaxRows);
  localparam int ColW        = $clog2(MaxCols);
  localparam int AddrW       = RowW + ColW;
  localparam int SizeW       = 9;
  localparam int DistW       = 34;

  localparam logic [DistW-1:0] DistStart = 34'd10000000000;

  localparam logic [1:0] RegRows   = 2'd0;
  localparam logic [1:0] RegCols   = 2'd1;
  localparam logic [1:0] RegRadius = 2'd2;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef enum logic [2:0] {
    MemNone,
    MemCentre,
    MemBrY,
    MemBrX,
    MemScan,
    MemEdgeA,
    MemEdgeB,
    MemPix
  } mem_op_e;

  // command from the controller to the datapath
  typedef struct packed {
    logic              init;      // start a query
    logic              bis_step;  // move the centre to the box midpoint
    logic              clr_found;
    mem_op_e           op;        // what the issued read is for
    logic [RowW-1:0]   row_a;
    logic [ColW-1:0]   col_a;
    logic [RowW-1:0]   row_b;
    logic [ColW-1:0]   col_b;
    logic              rd;        // issue read(s)
    logic              clr_min;
  } dp_cmd_t;

  typedef struct packed {
    logic [RowW-1:0] ib;
    logic [RowW-1:0] ie;
    logic [ColW-1:0] jb;
    logic [ColW-1:0] je;
    logic [RowW-1:0] ic;
    logic [ColW-1:0] jc;
    logic [1:0]      found;
    logic            busy;        // a read result is still in flight
  } dp_sts_t;

endpackage

>>> rtl/cgnr_datapath.sv
module cgnr_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [cgnr_pkg::AddrW-1:0] load_addr_i,
  input  logic signed [15:0]        load_x_i,
  input  logic signed [15:0]        load_y_i,
  input  logic [31:0]               load_pix_i,
  input  logic signed [15:0]        px_i,
  input  logic signed [15:0]        py_i,
  input  logic [cgnr_pkg::RowW-1:0] nr_m1_i,
  input  logic [cgnr_pkg::ColW-1:0] nc_m1_i,
  input  cgnr_pkg::dp_cmd_t         cmd_i,
  output cgnr_pkg::dp_sts_t         sts_o,
  output logic [cgnr_pkg::DistW-1:0] dmin_o,
  output logic [31:0]               pix_o
);
  localparam int RW = cgnr_pkg::RowW;
  localparam int CW = cgnr_pkg::ColW;
  localparam int AW = cgnr_pkg::AddrW;
  localparam int DW = cgnr_pkg::DistW;
  localparam int Depth = cgnr_pkg::MaxRows * cgnr_pkg::MaxCols;

  logic signed [15:0] xmem [Depth];
  logic signed [15:0] ymem [Depth];
  logic [31:0]        pmem [Depth];

  logic signed [15:0] xa_q, ya_q, xb_q, yb_q;
  logic [31:0]        pix_q;
  cgnr_pkg::mem_op_e  op_q;
  logic               vld_q;
  logic [RW-1:0]      r_q;
  logic [CW-1:0]      c_q;

  logic [RW-1:0] ib_q, ie_q, ic_q;
  logic [CW-1:0] jb_q, je_q, jc_q;
  logic [1:0]    found_q;
  logic [DW-1:0] dmin_q;

  logic [AW-1:0] addr_a, addr_b;
  assign addr_a = {cmd_i.row_a, cmd_i.col_a};
  assign addr_b = {cmd_i.row_b, cmd_i.col_b};

  // write on load; two-port read every cycle
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      xmem[load_addr_i] <= load_x_i;
      ymem[load_addr_i] <= load_y_i;
      pmem[load_addr_i] <= load_pix_i;
    end
    xa_q  <= xmem[addr_a];
    ya_q  <= ymem[addr_a];
    xb_q  <= xmem[addr_b];
    yb_q  <= ymem[addr_b];
    pix_q <= pmem[addr_a];
  end

  // squared distance of port A cell
  logic signed [16:0] dx, dy;
  logic [DW-1:0]      d;
  logic [16:0]        ax, bx, ay, by;
  logic [31:0]        sqx, sqy;
  assign dx = 17'(px_i) - 17'(xa_q);
  assign dy = 17'(py_i) - 17'(ya_q);
  assign ax = (dx < 0) ? 17'(-dx) : 17'(dx);
  assign ay = (dy < 0) ? 17'(-dy) : 17'(dy);
  // magnitudes never exceed 16 bits
  assign sqx = ax[15:0] * ax[15:0];
  assign sqy = ay[15:0] * ay[15:0];
  assign d   = DW'(sqx) + DW'(sqy);
  assign bx = (17'(px_i) - 17'(xb_q)) < 0 ? 17'(17'(xb_q) - 17'(px_i))
                                           : 17'(17'(px_i) - 17'(xb_q));
  assign by = (17'(py_i) - 17'(yb_q)) < 0 ? 17'(17'(yb_q) - 17'(py_i))
                                           : 17'(17'(py_i) - 17'(yb_q));

  logic [RW:0] isum;
  logic [CW:0] jsum;
  always_comb begin
    isum = {1'b0, ib_q} + {1'b0, ie_q};
    jsum = {1'b0, jb_q} + {1'b0, je_q};
  end

  // hold box, flags and running minimum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      op_q  <= cgnr_pkg::MemNone;
      found_q <= '0;
      r_q <= '0; c_q <= '0;
      ib_q <= '0; ie_q <= '0; ic_q <= '0;
      jb_q <= '0; je_q <= '0; jc_q <= '0;
      dmin_q <= cgnr_pkg::DistStart;
    end else begin
      vld_q <= cmd_i.rd;
      op_q  <= cmd_i.op;
      r_q   <= cmd_i.row_a;
      c_q   <= cmd_i.col_a;
      if (cmd_i.init) begin
        ib_q <= '0; ie_q <= nr_m1_i; jb_q <= '0; je_q <= nc_m1_i;
        ic_q <= RW'(nr_m1_i >> 1); jc_q <= CW'(nc_m1_i >> 1);
      end
      if (cmd_i.clr_found) found_q <= '0;
      if (cmd_i.clr_min) dmin_q <= cgnr_pkg::DistStart;
      if (cmd_i.bis_step) begin
        ic_q <= RW'(isum >> 1);
        jc_q <= CW'(jsum >> 1);
      end
      if (vld_q) begin
        case (op_q)
          cgnr_pkg::MemCentre: begin
            if (py_i < ya_q) ie_q <= ic_q; else ib_q <= ic_q;
            if (px_i < xa_q) je_q <= jc_q; else jb_q <= jc_q;
          end
          cgnr_pkg::MemBrY:
            if (ya_q <= py_i && yb_q >= py_i) found_q[1] <= 1'b1;
          cgnr_pkg::MemBrX:
            if (xa_q <= px_i && xb_q >= px_i) found_q[0] <= 1'b1;
          cgnr_pkg::MemScan:
            if (d < dmin_q) begin
              dmin_q <= d; ic_q <= r_q; jc_q <= c_q;
            end
          cgnr_pkg::MemEdgeA: begin
            if (found_q == 2'b10) jc_q <= (ax < bx) ? '0 : nc_m1_i;
            else                  ic_q <= (ay < by) ? '0 : nr_m1_i;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    sts_o.ib = ib_q; sts_o.ie = ie_q; sts_o.jb = jb_q; sts_o.je = je_q;
    sts_o.ic = ic_q; sts_o.jc = jc_q; sts_o.found = found_q;
    sts_o.busy = vld_q;
  end
  assign dmin_o = dmin_q;
  assign pix_o  = pix_q;
endmodule

>>> rtl/cgnr_ctrl.sv
module cgnr_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [cgnr_pkg::RowW-1:0] nr_m1_i,
  input  logic [cgnr_pkg::ColW-1:0] nc_m1_i,
  input  cgnr_pkg::dp_sts_t         sts_i,
  output cgnr_pkg::dp_cmd_t         cmd_o,
  output logic                      done_o,
  output logic                      fail_o
);
  localparam int RW = cgnr_pkg::RowW;
  localparam int CW = cgnr_pkg::ColW;

  typedef enum logic [3:0] {
    Idle, BisTest, BisWait, BisStep, BrY, BrX, BrWait, Pick,
    EdgeWait, Scan, ScanWait, PixWait, Done
  } state_e;

  state_e        state_q;
  logic [RW-1:0] i_q;
  logic [CW-1:0] j_q;
  logic          done_q, fail_q;

  logic [RW:0] iext;
  logic [CW:0] jext;
  assign iext = {1'b0, sts_i.ie} - {1'b0, sts_i.ib};
  assign jext = {1'b0, sts_i.je} - {1'b0, sts_i.jb};

  logic row_mode, col_mode;
  assign row_mode = sts_i.found == 2'b01; // scan one edge row
  assign col_mode = sts_i.found == 2'b10; // scan one edge column

  always_comb begin
    cmd_o = '0;
    cmd_o.op = cgnr_pkg::MemNone;
    case (state_q)
      Idle: if (start_i) begin
        cmd_o.init = 1'b1; cmd_o.clr_found = 1'b1; cmd_o.clr_min = 1'b1;
      end
      BisTest: if (iext > (RW+1)'(cgnr_pkg::BisectLimit) &&
                   jext > (CW+1)'(cgnr_pkg::BisectLimit)) begin
        cmd_o.rd = 1'b1; cmd_o.op = cgnr_pkg::MemCentre;
        cmd_o.row_a = sts_i.ic; cmd_o.col_a = sts_i.jc;
      end
      BisStep: cmd_o.bis_step = 1'b1;
      BrY: begin
        cmd_o.rd = 1'b1; cmd_o.op = cgnr_pkg::MemBrY;
        cmd_o.row_a = sts_i.ib; cmd_o.col_a = j_q;
        cmd_o.row_b = sts_i.ie; cmd_o.col_b = j_q;
      end
      BrX: begin
        cmd_o.rd = 1'b1; cmd_o.op = cgnr_pkg::MemBrX;
        cmd_o.row_a = i_q; cmd_o.col_a = sts_i.jb;
        cmd_o.row_b = i_q; cmd_o.col_b = sts_i.je;
      end
      Pick: if (row_mode || col_mode) begin
        cmd_o.rd = 1'b1; cmd_o.op = cgnr_pkg::MemEdgeA;
        if (col_mode) begin
          cmd_o.row_a = sts_i.ic; cmd_o.col_a = '0;
          cmd_o.row_b = sts_i.ic; cmd_o.col_b = nc_m1_i;
        end else begin
          cmd_o.row_a = '0; cmd_o.col_a = sts_i.jc;
          cmd_o.row_b = nr_m1_i; cmd_o.col_b = sts_i.jc;
        end
      end
      Scan: begin
        cmd_o.rd = 1'b1; cmd_o.op = cgnr_pkg::MemScan;
        cmd_o.row_a = row_mode ? sts_i.ic : i_q;
        cmd_o.col_a = col_mode ? sts_i.jc : j_q;
      end
      ScanWait: if (!sts_i.busy) begin
        cmd_o.rd = 1'b1; cmd_o.op = cgnr_pkg::MemPix;
        cmd_o.row_a = sts_i.ic; cmd_o.col_a = sts_i.jc;
      end
      // keep the pixel read on the found cell until the result is taken
      PixWait: begin
        cmd_o.row_a = sts_i.ic; cmd_o.col_a = sts_i.jc;
      end
      default: ;
    endcase
  end

  // sequence bisection, bracket tests and scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle; i_q <= '0; j_q <= '0; done_q <= 1'b0; fail_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        Idle: if (start_i) state_q <= BisTest;
        BisTest: begin
          if (cmd_o.rd) state_q <= BisWait;
          else begin
            state_q <= BrY; j_q <= sts_i.jb;
          end
        end
        BisWait: state_q <= BisStep;
        BisStep: state_q <= BisTest;
        BrY: begin
          if (j_q == sts_i.je) begin
            state_q <= BrX; i_q <= sts_i.ib;
          end else j_q <= j_q + 1'b1;
        end
        BrX: begin
          if (i_q == sts_i.ie) state_q <= BrWait;
          else i_q <= i_q + 1'b1;
        end
        BrWait: if (!sts_i.busy) state_q <= Pick;
        Pick: begin
          i_q <= sts_i.ib; j_q <= sts_i.jb;
          if (sts_i.found == 2'b00) begin
            fail_q <= 1'b1; done_q <= 1'b1; state_q <= Idle;
          end else if (sts_i.found == 2'b11) state_q <= Scan;
          else state_q <= EdgeWait;
        end
        EdgeWait: if (!sts_i.busy) state_q <= Scan;
        Scan: begin
          if ((row_mode || i_q == sts_i.ie) && (col_mode || j_q == sts_i.je))
            state_q <= ScanWait;
          else if (!row_mode && (col_mode || j_q == sts_i.je)) begin
            i_q <= i_q + 1'b1; j_q <= sts_i.jb;
          end else j_q <= j_q + 1'b1;
        end
        ScanWait: if (!sts_i.busy) state_q <= PixWait;
        PixWait: begin
          fail_q <= 1'b0; done_q <= 1'b1; state_q <= Idle;
        end
        default: state_q <= Idle;
      endcase
    end
  end

  assign done_o = done_q;
  assign fail_o = fail_q;
endmodule

>>> rtl/curvilinear_grid_nearest_remap.sv
// Operation: a load writes one cell; a query runs bisect steps, bracket
//   tests over the row and column extents of the box, an optional edge pick
//   and a scan, one distance per cycle through the grid memory's read port;
//   a failed search ends after the bracket tests.
// Throughput: one query at a time; loads are accepted whenever idle with no result pending.
// Reset (rst_ni, async low): control and registers return to reset values;
//   the grid memory is not cleared.
module curvilinear_grid_nearest_remap (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // row_index[7:0], col_index[15:8], coord_x[31:16], coord_y[47:32],
  // pixel_value[79:48]
  input  logic [79:0]  s_axis_tdata,
  // cmd[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // value_out[31:0], nearest_row[39:32], nearest_col[47:40],
  // nearest_dist_sq[80:48], pad zeros
  output logic [87:0]  m_axis_tdata,
  // within_radius[0], search_failed[1]
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [32:0]  cfg_wdata_i
);
  localparam int RW = cgnr_pkg::RowW;
  localparam int CW = cgnr_pkg::ColW;

  logic [8:0]  rows_q, cols_q;
  logic [32:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 9'd256; cols_q <= 9'd256; radius_q <= 33'd8589672450;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cgnr_pkg::RegRows:   rows_q <= cfg_wdata_i[8:0];
        cgnr_pkg::RegCols:   cols_q <= cfg_wdata_i[8:0];
        cgnr_pkg::RegRadius: radius_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamp grid size to 1..max
  logic [RW-1:0] nr_m1;
  logic [CW-1:0] nc_m1;
  always_comb begin
    if (rows_q == '0) nr_m1 = '0;
    else if (rows_q > 9'(cgnr_pkg::MaxRows)) nr_m1 = RW'(cgnr_pkg::MaxRows - 1);
    else nr_m1 = RW'(rows_q - 9'd1);
    if (cols_q == '0) nc_m1 = '0;
    else if (cols_q > 9'(cgnr_pkg::MaxCols)) nc_m1 = CW'(cgnr_pkg::MaxCols - 1);
    else nc_m1 = CW'(cols_q - 9'd1);
  end

  logic busy_q, out_v_q;
  logic signed [15:0] px_q, py_q;
  logic acc, is_load, start, done, fail;

  assign s_axis_tready = !busy_q && !out_v_q;
  assign acc     = s_axis_tvalid && s_axis_tready;
  assign is_load = acc && (s_axis_tuser == cgnr_pkg::CmdLoad);
  assign start   = acc && (s_axis_tuser == cgnr_pkg::CmdQuery);

  cgnr_pkg::dp_cmd_t cmd;
  cgnr_pkg::dp_sts_t sts;
  logic [cgnr_pkg::DistW-1:0] dmin;
  logic [31:0] pix;

  cgnr_datapath u_dp (
    .clk_i, .rst_ni,
    .load_i      (is_load),
    .load_addr_i ({s_axis_tdata[RW-1:0], s_axis_tdata[8+CW-1:8]}),
    .load_x_i    (s_axis_tdata[31:16]),
    .load_y_i    (s_axis_tdata[47:32]),
    .load_pix_i  (s_axis_tdata[79:48]),
    .px_i        (px_q),
    .py_i        (py_q),
    .nr_m1_i     (nr_m1),
    .nc_m1_i     (nc_m1),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .dmin_o      (dmin),
    .pix_o       (pix)
  );

  cgnr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i (start),
    .nr_m1_i (nr_m1),
    .nc_m1_i (nc_m1),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .done_o  (done),
    .fail_o  (fail)
  );

  logic [87:0] od_q;
  logic [1:0]  ou_q;
  logic        hit;
  assign hit = dmin < {1'b0, radius_q};

  // hold the query point, register the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; out_v_q <= 1'b0;
      px_q <= '0; py_q <= '0; od_q <= '0; ou_q <= '0;
    end else begin
      if (start) begin
        busy_q <= 1'b1;
        px_q <= s_axis_tdata[31:16];
        py_q <= s_axis_tdata[47:32];
      end
      if (done) begin
        busy_q <= 1'b0; out_v_q <= 1'b1;
        if (fail) begin
          od_q <= '0; ou_q <= 2'b10;
        end else begin
          od_q <= {7'd0, dmin[32:0], 8'(sts.jc), 8'(sts.ic), hit ? pix : 32'd0};
          ou_q <= {1'b0, hit};
        end
      end else if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;
endmodule

>>> rtl/cgnr_checker.sv
module cgnr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0 && !m_axis_tuser[0])
    else $error("failed search with non-zero fields");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:0] == '0)
    else $error("value without hit");
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
endmodule

bind curvilinear_grid_nearest_remap cgnr_checker u_chk (.*);
